/* hdl/cbe_pkg.sv */
// ----------------------------------------------------------------------------
// cbe_pkg
// Types and constants shared by the CBOR item head encoder modules.
// ----------------------------------------------------------------------------
package cbe_pkg;

	// Request function codes
	localparam logic [3:0] FUNC_HEAD       = 4'd0;
	localparam logic [3:0] FUNC_SIGNED     = 4'd1;
	localparam logic [3:0] FUNC_BOOL       = 4'd2;
	localparam logic [3:0] FUNC_NULL       = 4'd3;
	localparam logic [3:0] FUNC_SIMPLE     = 4'd4;
	localparam logic [3:0] FUNC_INDEF      = 4'd5;
	localparam logic [3:0] FUNC_BREAK      = 4'd6;
	localparam logic [3:0] FUNC_HALF       = 4'd7;
	localparam logic [3:0] FUNC_PAYLOAD    = 4'd8;

	// Additional info codes
	localparam logic [4:0] AI_ONE_BYTE     = 5'd24;
	localparam logic [4:0] AI_TWO_BYTES    = 5'd25;
	localparam logic [4:0] AI_FOUR_BYTES   = 5'd26;
	localparam logic [4:0] AI_EIGHT_BYTES  = 5'd27;
	localparam logic [4:0] AI_INDEFINITE   = 5'd31;

	// Fixed major type 7 bytes
	localparam logic [7:0] BYTE_FALSE      = 8'hf4;
	localparam logic [7:0] BYTE_TRUE       = 8'hf5;
	localparam logic [7:0] BYTE_NULL       = 8'hf6;
	localparam logic [7:0] BYTE_SIMPLE8    = 8'hf8;
	localparam logic [7:0] BYTE_HALF       = 8'hf9;
	localparam logic [7:0] BYTE_BREAK      = 8'hff;
	localparam logic [7:0] BYTE_SIMPLE_LOW = 8'he0;

	localparam logic [2:0] MAJOR_UINT      = 3'd0;
	localparam logic [2:0] MAJOR_NINT      = 3'd1;

	// Longest encoding is a head byte plus eight argument bytes
	localparam int MAX_BYTES = 9;
	localparam int LEN_W     = 4;

	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic [3:0]         func;
		logic [2:0]         major;
		logic [63:0]        argument;
		logic signed [63:0] signed_value;
		logic               bool_value;
		logic [7:0]         simple_value;
		logic [15:0]        half_bits;
		logic [7:0]         payload_byte;
	} request_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} result_t;

	// Byte run for one item, first byte in the top byte lane
	typedef struct packed {
		len_t                       len;
		logic [8*MAX_BYTES-1:0]     bytes;
	} desc_t;

endpackage

/* hdl/cbor_item_head_encoder_core.sv */
// ----------------------------------------------------------------------------
// cbor_item_head_encoder_core
// CBOR (RFC 8949) encoder for heads, simple items and string payload bytes.
// ----------------------------------------------------------------------------
// Each request yields a run of 1 to 9 CBOR bytes, the last one flagged with
// last_byte; unused function codes are accepted and yield nothing. The byte
// output sustains one byte per cycle while pop keeps up, so an item holds the
// output for its whole byte run (payload bytes, break, bool and null: one
// byte; a 64-bit head: nine bytes). Requests are taken every cycle while the
// run queue (DEPTH entries) has room; each passes the queue and then the
// serializer's output register. The back end serializer sets the rate.
module cbor_item_head_encoder_core
	import cbe_pkg::*;
#(
	parameter int DEPTH = 2
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  request_t request,
	output logic     empty,
	input  logic     pop,
	output result_t  result
);

	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	desc_t q_wdata;
	desc_t q_rdata;

	// Classification front end
	cbe_front u_front (
		.push    (push),
		.full    (full),
		.request (request),
		.q_full  (q_full),
		.q_push  (q_push),
		.desc    (q_wdata)
	);

	// Run queue
	cbe_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Byte serializer back end
	cbe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

/* hdl/cbe_front.sv */
// ----------------------------------------------------------------------------
// cbe_front
// Accepts requests, classifies them and builds the byte run of each item.
// ----------------------------------------------------------------------------
module cbe_front
	import cbe_pkg::*;
(
	input  logic     push,
	output logic     full,
	input  request_t request,
	input  logic     q_full,
	output logic     q_push,
	output desc_t    desc
);

	// Shortest head form for a major type and a 64-bit argument
	function automatic desc_t head_run(input logic [2:0] mj, input logic [63:0] arg);
		desc_t d;
		d = '0;
		if (arg[63:5] == '0 && arg[4:0] < AI_ONE_BYTE) begin
			d.len   = len_t'(1);
			d.bytes = {mj, arg[4:0], 64'd0};
		end else if (arg[63:8] == '0) begin
			d.len   = len_t'(2);
			d.bytes = {mj, AI_ONE_BYTE, arg[7:0], 56'd0};
		end else if (arg[63:16] == '0) begin
			d.len   = len_t'(3);
			d.bytes = {mj, AI_TWO_BYTES, arg[15:0], 48'd0};
		end else if (arg[63:32] == '0) begin
			d.len   = len_t'(5);
			d.bytes = {mj, AI_FOUR_BYTES, arg[31:0], 32'd0};
		end else begin
			d.len   = len_t'(9);
			d.bytes = {mj, AI_EIGHT_BYTES, arg};
		end
		return d;
	endfunction

	logic  known;
	logic  neg;
	desc_t run;

	// Classify the request
	always_comb begin
		neg   = request.signed_value[63];
		known = 1'b1;
		run   = '0;
		case (request.func)
			FUNC_HEAD: begin
				run = head_run(request.major, request.argument);
			end
			FUNC_SIGNED: begin
				// negative n encodes as major 1 with argument -1-n
				run = neg ? head_run(MAJOR_NINT, ~request.signed_value)
				          : head_run(MAJOR_UINT, request.signed_value);
			end
			FUNC_BOOL: begin
				run.len   = len_t'(1);
				run.bytes = {(request.bool_value ? BYTE_TRUE : BYTE_FALSE), 64'd0};
			end
			FUNC_NULL: begin
				run.len   = len_t'(1);
				run.bytes = {BYTE_NULL, 64'd0};
			end
			FUNC_SIMPLE: begin
				if (request.simple_value[7:5] == 3'd0) begin
					run.len   = len_t'(1);
					run.bytes = {BYTE_SIMPLE_LOW | request.simple_value, 64'd0};
				end else begin
					run.len   = len_t'(2);
					run.bytes = {BYTE_SIMPLE8, request.simple_value, 56'd0};
				end
			end
			FUNC_INDEF: begin
				run.len   = len_t'(1);
				run.bytes = {request.major, AI_INDEFINITE, 64'd0};
			end
			FUNC_BREAK: begin
				run.len   = len_t'(1);
				run.bytes = {BYTE_BREAK, 64'd0};
			end
			FUNC_HALF: begin
				run.len   = len_t'(3);
				run.bytes = {BYTE_HALF, request.half_bits, 48'd0};
			end
			FUNC_PAYLOAD: begin
				run.len   = len_t'(1);
				run.bytes = {request.payload_byte, 64'd0};
			end
			default: begin
				// unused codes yield no bytes and are dropped
				known = 1'b0;
			end
		endcase
	end

	assign full   = q_full;
	assign q_push = push & ~q_full & known;
	assign desc   = run;

endmodule

/* hdl/cbe_queue.sv */
// ----------------------------------------------------------------------------
// cbe_queue
// Short register queue of byte runs between front and back.
// ----------------------------------------------------------------------------
module cbe_queue
	import cbe_pkg::*;
#(
	parameter int DEPTH = 2
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  desc_t wdata,
	input  logic  rd,
	output desc_t rdata,
	output logic  full,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !rd) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

/* hdl/cbe_back.sv */
// ----------------------------------------------------------------------------
// cbe_back
// Serializes byte runs into the result queue port, one byte per cycle while pop keeps up.
// ----------------------------------------------------------------------------
module cbe_back
	import cbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  desc_t   q_head,
	input  logic    q_empty,
	output logic    q_pop,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	localparam int DW = 8 * MAX_BYTES;

	logic          active_q;
	len_t          len_q;
	logic [DW-1:0] data_q;
	logic          out_valid_q;
	result_t       out_q;

	logic          out_adv;
	logic          src_valid;
	len_t          src_len;
	logic [DW-1:0] src_bytes;
	logic          src_last;

	// Next byte comes from the run in progress, else from the queue head
	always_comb begin
		src_valid = active_q | ~q_empty;
		src_len   = active_q ? len_q  : q_head.len;
		src_bytes = active_q ? data_q : q_head.bytes;
		src_last  = (src_len == len_t'(1));
		out_adv   = ~out_valid_q | pop;
		q_pop     = out_adv & ~active_q & ~q_empty;
	end

	// Run and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= src_valid;
			if (src_valid) begin
				active_q <= ~src_last;
				len_q    <= src_len - 1'b1;
			end
		end
	end

	// Byte shifter and output register
	always_ff @(posedge clk) begin
		if (out_adv && src_valid) begin
			data_q            <= {src_bytes[DW-9:0], 8'h00};
			out_q.out_byte    <= src_bytes[DW-1:DW-8];
			out_q.last_byte   <= src_last;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = out_q;

	// Checks
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (len_q != '0)) else $error("active run with no bytes left");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last_byte && pop) |=> out_valid_q)
		else $error("gap inside a byte run");
	a_no_pop_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !q_pop) else $error("queue read during a run");

endmodule
